/* sv/assert_macros.svh */
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/ebam_pkg.sv */
// Package: sizes, codes and bank control types of the byte-addressed memory.
package ebam_pkg;

	// memory size in bytes; a power of two, at least 4
	localparam int MEM_BYTES = 65536;
	localparam int NBANKS    = 4;
	localparam int BANK_DEPTH = MEM_BYTES / NBANKS;
	localparam int ROW_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int ADDR_W    = 32;
	localparam int DATA_W    = 32;

	typedef enum logic {
		FUNC_READ  = 1'b0,
		FUNC_WRITE = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		SIZE_BYTE = 2'd0,
		SIZE_HALF = 2'd1,
		SIZE_WORD = 2'd2
	} size_t;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	// per-bank control for one access
	typedef struct packed {
		logic             en;     // bank holds a byte of this access
		logic [ROW_W-1:0] row;    // row within the bank
		logic [7:0]       wbyte;  // byte to store on a write
		logic [1:0]       pos;    // byte position within the value
	} bank_req_t;

	typedef struct packed {
		logic                    err;
		bank_req_t [NBANKS-1:0]  bank;
	} decode_t;

endpackage

/* sv/ebam_ifs.sv */
// Request and response channel interfaces of the byte-addressed memory.
interface ebam_req_if;
	logic                        valid;
	logic                        ready;
	logic                        func;
	logic [1:0]                  access_size;
	logic [ebam_pkg::ADDR_W-1:0] byte_address;
	logic [ebam_pkg::DATA_W-1:0] write_data;

	modport source (output valid, func, access_size, byte_address, write_data,
		input ready);
	modport sink (input valid, func, access_size, byte_address, write_data,
		output ready);
endinterface

interface ebam_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [ebam_pkg::DATA_W-1:0] read_data;
	logic                        status;

	modport source (output valid, read_data, status, input ready);
	modport sink (input valid, read_data, status, output ready);
endinterface

/* sv/ebam_bank_ram.sv */
// Generic single-port byte bank with registered read data.
module ebam_bank_ram #(
	parameter int DEPTH = 16384,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

/* sv/ebam_decode.sv */
// Access decode: bounds check and per-bank row, lane and byte steering.
module ebam_decode (
	input  logic [1:0]                  access_size,
	input  logic [ebam_pkg::ADDR_W-1:0] byte_address,
	input  logic [ebam_pkg::DATA_W-1:0] write_data,
	input  logic                        big_endian,
	output ebam_pkg::decode_t           dec
);

	logic [1:0]                    last;     // bytes in access minus one
	logic                          bad_size;
	logic [ebam_pkg::ADDR_W:0]     end_addr;
	logic                          err;
	logic [1:0]                    lo;
	logic [ebam_pkg::ROW_W-1:0]    row0;

	assign lo   = byte_address[1:0];
	assign row0 = byte_address[ebam_pkg::ROW_W+1:2];

	always_comb begin
		bad_size = 1'b0;
		case (ebam_pkg::size_t'(access_size))
			ebam_pkg::SIZE_BYTE: last = 2'd0;
			ebam_pkg::SIZE_HALF: last = 2'd1;
			ebam_pkg::SIZE_WORD: last = 2'd3;
			default: begin
				last     = 2'd0;
				bad_size = 1'b1;
			end
		endcase
	end

	// one past the last byte must not exceed the memory size
	assign end_addr = {1'b0, byte_address} + (ebam_pkg::ADDR_W+1)'(last)
		+ (ebam_pkg::ADDR_W+1)'(1);
	assign err = bad_size || (end_addr > (ebam_pkg::ADDR_W+1)'(ebam_pkg::MEM_BYTES));

	always_comb begin
		logic [1:0] k;
		logic [1:0] p;
		dec.err = err;
		for (int b = 0; b < ebam_pkg::NBANKS; b++) begin
			k = 2'(b) - lo;
			p = big_endian ? (last - k) : k;
			dec.bank[b].en    = !err && (k <= last);
			dec.bank[b].row   = row0 + ebam_pkg::ROW_W'(2'(b) < lo);
			dec.bank[b].pos   = p;
			dec.bank[b].wbyte = write_data[{p, 3'b000} +: 8];
		end
	end

endmodule

/* sv/endian_byte_addressed_memory.sv */
// Top level: byte-addressed memory with selectable byte order.
// Usage:
//   req  (sink)  : one access per item: func (0 read, 1 write), access_size
//                  (0 byte, 1 halfword, 2 word), byte_address, write_data.
//   rsp  (source): one item per request: read_data (zero-extended, zero on
//                  writes and errors) and status (0 done, 1 outside memory or bad size code).
//   cfg_we/cfg_wdata: byte order, 1 big-endian, 0 little-endian; write it
//                  only while no request is in flight.
// The store is four byte-wide banks; byte a lives in bank a[1:0], row a>>2,
// so any unaligned word touches each bank at most once and is served by a
// single read or write of all four banks in the accept cycle.
// The banks are read at the accept edge into the bank-read stage; the response
// register loads as that stage advances, and rsp.valid rises with it. Throughput:
// one item per cycle while rsp is not stalled, set by the single port of each bank.
// A write lands in the banks at the accept edge, so a read accepted at any
// later edge sees it; no forwarding is needed.
// When rsp is stalled the item in the bank-read stage holds (bank outputs
// are not re-read) and req.ready drops; nothing is lost.
// Reset clears the pipeline valids and selects little-endian; bank contents
// are undefined until written and need no clearing pass.
`include "assert_macros.svh"

module endian_byte_addressed_memory (
	input  logic           clk,
	input  logic           arst_n,
	ebam_req_if.sink       req,
	ebam_rsp_if.source     rsp,
	input  logic           cfg_we,
	input  logic           cfg_wdata
);

	logic                                     big_endian_q;
	ebam_pkg::decode_t                        dec;
	logic                                     accept;
	logic                                     is_write;
	logic                                     out_free;
	logic                                     adv_s1;

	// bank-read stage
	logic                                     valid_s1;
	logic                                     err_s1;
	logic                                     is_read_s1;
	logic [ebam_pkg::NBANKS-1:0]              en_s1;
	logic [ebam_pkg::NBANKS-1:0][1:0]         pos_s1;
	logic [7:0]                               bank_q [ebam_pkg::NBANKS];

	// response register
	logic                                     rsp_valid_q;
	logic [ebam_pkg::DATA_W-1:0]              read_data_q;
	logic                                     status_q;
	logic [ebam_pkg::DATA_W-1:0]              merged;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b0;
		end else if (cfg_we) begin
			big_endian_q <= cfg_wdata;
		end
	end

	ebam_decode u_decode (
		.access_size  (req.access_size),
		.byte_address (req.byte_address),
		.write_data   (req.write_data),
		.big_endian   (big_endian_q),
		.dec          (dec)
	);

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign adv_s1    = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;
	assign accept    = req.valid && req.ready;
	assign is_write  = (ebam_pkg::func_t'(req.func) == ebam_pkg::FUNC_WRITE);

	// four byte banks; each one the access touches is read or written in the accept cycle
	for (genvar b = 0; b < ebam_pkg::NBANKS; b++) begin : g_bank
		ebam_bank_ram #(
			.DEPTH (ebam_pkg::BANK_DEPTH),
			.WIDTH (8)
		) u_ram (
			.clk   (clk),
			.we    (accept && is_write && dec.bank[b].en),
			.re    (accept && !is_write && dec.bank[b].en),
			.addr  (dec.bank[b].row),
			.wdata (dec.bank[b].wbyte),
			.rdata (bank_q[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_s1     <= dec.err;
			is_read_s1 <= !is_write;
			for (int b = 0; b < ebam_pkg::NBANKS; b++) begin
				en_s1[b]  <= dec.bank[b].en;
				pos_s1[b] <= dec.bank[b].pos;
			end
		end
	end

	// place each bank byte at its position in the value
	always_comb begin
		merged = '0;
		for (int b = 0; b < ebam_pkg::NBANKS; b++) begin
			if (en_s1[b]) begin
				merged = merged | (ebam_pkg::DATA_W'(bank_q[b]) << {pos_s1[b], 3'b000});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			read_data_q <= (is_read_s1 && !err_s1) ? merged : '0;
			status_q    <= err_s1 ? ebam_pkg::STATUS_ERR : ebam_pkg::STATUS_OK;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = read_data_q;
	assign rsp.status    = status_q;

	// checks
	`ASSERT_IMPL(a_err_no_bank, valid_s1 && err_s1, en_s1 == '0, "bank enabled on error")
	`ASSERT_NEXT(a_s1_holds, valid_s1 && !out_free, valid_s1 && rsp_valid_q, "stalled item lost")
	`ASSERT_IMPL(a_err_zero, rsp_valid_q && (status_q == ebam_pkg::STATUS_ERR), read_data_q == '0, "error with data")
	`ASSERT_NEXT(a_rsp_follows, adv_s1, rsp_valid_q, "response not registered")

endmodule

/* test/endian_byte_addressed_memory_tb.sv */
// Testbench for endian_byte_addressed_memory: random and directed accesses, byte-level predictor.
module endian_byte_addressed_memory_tb;

	localparam int   HALF_PERIOD  = 5;
	localparam int   RESET_CYCLES = 12;
	localparam int   RUN_LIMIT    = 5_000_000;  // time units, far beyond the slowest clean run
	localparam int   SETTLE       = 4;          // two-stage pipeline plus margin
	localparam int   HOLD_CYCLES  = 64;         // long receiver hold-off
	localparam int   WIN          = 48;         // hot windows at both ends of memory
	localparam int   PHASE_ITEMS  = 125;
	localparam int   MEM_SZ       = ebam_pkg::MEM_BYTES;
	// size code with no access width; the block must flag it
	localparam logic [1:0] SIZE_UNUSED = 2'd3;

	typedef struct packed {
		ebam_pkg::func_t func;
		logic [1:0]      size;
		logic [31:0]     addr;
		logic [31:0]     wdata;
	} access_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        status;
	} result_t;

	// Byte image of the memory plus the queue of responses still owed.
	class mem_scoreboard;
		logic [7:0] image [MEM_SZ];
		bit         big_endian;
		result_t    owed [$];

		function int pending();
			return owed.size();
		endfunction

		function void note_access(access_t a);
			result_t     r;
			int unsigned nbytes;
			int unsigned sh;
			logic [31:0] ad;
			r.read_data = '0;
			r.status    = ebam_pkg::STATUS_ERR;
			if (a.size != SIZE_UNUSED) begin
				nbytes = 1 << a.size;
				if ({1'b0, a.addr} + nbytes <= MEM_SZ) begin
					for (int k = 0; k < nbytes; k++) begin
						ad = a.addr + k;
						sh = big_endian ? 8 * (nbytes - 1 - k) : 8 * k;
						if (a.func == ebam_pkg::FUNC_WRITE)
							image[ad] = a.wdata[sh +: 8];
						else
							r.read_data |= 32'(image[ad]) << sh;
					end
					r.status = ebam_pkg::STATUS_OK;
				end
			end
			owed.push_back(r);
		endfunction

		// Empty string when the response matches the oldest one owed.
		function string check_result(logic [31:0] rd, logic st);
			result_t w;
			string   s;
			if (owed.size() == 0)
				return $sformatf("response with none owed: read_data %h status %b", rd, st);
			w = owed.pop_front();
			s = "";
			if (rd !== w.read_data)
				s = $sformatf("read_data %h, expected %h", rd, w.read_data);
			if (st !== w.status)
				s = {s, (s == "") ? "" : "; ", $sformatf("status %b, expected %b", st, w.status)};
			return s;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	ebam_req_if req_ch ();
	ebam_rsp_if rsp_ch ();

	endian_byte_addressed_memory u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	mem_scoreboard sb = new();
	int  errors;
	// bytes the stimulus has stored; reads only ever cover these
	bit  touched [MEM_SZ];
	// receiver does its long hold-off once the random traffic is running
	bit  in_random;
	bit  hold_pending = 1'b1;

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		errors++;
	endtask

	// Monitor: everything is sampled at the rising edge, before the block's
	// registers update, so the order of processes in the step does not matter.
	always @(posedge clk) begin : monitor
		string msg;
		access_t a;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				a.func  = ebam_pkg::func_t'(req_ch.func);
				a.size  = req_ch.access_size;
				a.addr  = req_ch.byte_address;
				a.wdata = req_ch.write_data;
				sb.note_access(a);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				msg = sb.check_result(rsp_ch.read_data, rsp_ch.status);
				if (msg != "")
					report_mismatch(msg);
			end
			// only written while idle, so order against the items is moot
			if (cfg_we)
				sb.big_endian = cfg_wdata;
		end
	end

	function automatic access_t mk(ebam_pkg::func_t f, logic [1:0] size, logic [31:0] addr,
		logic [31:0] wdata);
		access_t a;
		a.func  = f;
		a.size  = size;
		a.addr  = addr;
		a.wdata = wdata;
		return a;
	endfunction

	// Address with every byte inside memory; mostly in the hot windows so
	// reads find stored bytes.
	function automatic logic [31:0] in_range_addr(int unsigned nbytes);
		case ($urandom_range(0, 3))
			0, 1: begin
				return $urandom_range(0, WIN - nbytes);
			end
			2: begin
				return $urandom_range(MEM_SZ - WIN, MEM_SZ - nbytes);
			end
			default: begin
				return $urandom_range(0, MEM_SZ - nbytes);
			end
		endcase
	endfunction

	// Mostly legal accesses; about a tenth fall outside memory (straddling the
	// top or far above it) and a few use the unused size code.
	function automatic access_t random_access();
		access_t     a;
		int unsigned nbytes;
		int unsigned roll;
		bit          ok;
		a.func  = $urandom_range(0, 1) ? ebam_pkg::FUNC_WRITE : ebam_pkg::FUNC_READ;
		a.size  = 2'($urandom_range(ebam_pkg::SIZE_BYTE, ebam_pkg::SIZE_WORD));
		a.wdata = $urandom();
		roll    = $urandom_range(0, 99);
		if (roll < 5) begin
			a.size = SIZE_UNUSED;
			a.addr = $urandom();
			return a;
		end
		nbytes = 1 << a.size;
		if (roll < 15) begin
			if ($urandom_range(0, 1))
				a.addr = $urandom_range(MEM_SZ - nbytes + 1, MEM_SZ + 3);
			else
				a.addr = $urandom_range(MEM_SZ, 32'hFFFF_FFFF);
			return a;
		end
		a.addr = in_range_addr(nbytes);
		if (a.func == ebam_pkg::FUNC_READ) begin
			// never read a byte that was not stored; give up and write instead
			ok = 1'b0;
			for (int t = 0; t < 8 && !ok; t++) begin
				a.addr = in_range_addr(nbytes);
				ok = 1'b1;
				for (int k = 0; k < nbytes; k++)
					if (!touched[a.addr + k])
						ok = 1'b0;
			end
			if (!ok)
				a.func = ebam_pkg::FUNC_WRITE;
		end
		return a;
	endfunction

	// Offers one item from a falling edge and returns at the falling edge
	// after it is taken; valid stays high for a following item.
	task automatic drive_item(input access_t a);
		int unsigned nbytes;
		nbytes = 1 << a.size;
		if (a.func == ebam_pkg::FUNC_WRITE && a.size != SIZE_UNUSED &&
			{1'b0, a.addr} + nbytes <= MEM_SZ)
			for (int k = 0; k < nbytes; k++)
				touched[a.addr + k] = 1'b1;
		req_ch.valid        <= 1'b1;
		req_ch.func         <= a.func;
		req_ch.access_size  <= a.size;
		req_ch.byte_address <= a.addr;
		req_ch.write_data   <= a.wdata;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Byte order may change only with nothing in flight.
	task automatic set_byte_order(input bit big);
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= big;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Bursts of back-to-back items with random gaps; some bursts run on
	// into the next with no gap at all.
	task automatic run_random(input int count);
		int left;
		int burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 16);
			if (burst > left)
				burst = left;
			repeat (burst) drive_item(random_access());
			left -= burst;
			if ($urandom_range(0, 3) != 0) begin
				req_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
	endtask

	// Receiver: segments of always-ready, random, and one-in-three patterns,
	// plus one long hold-off that backs the pipeline up into the request side.
	initial begin : rsp_sink
		int mode;
		int seg;
		int n;
		rsp_ch.ready <= 1'b0;
		wait (arst_n);
		n = 0;
		forever begin
			if (hold_pending && in_random) begin
				hold_pending = 1'b0;
				@(negedge clk);
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end
			mode = $urandom_range(0, 3);
			seg  = $urandom_range(8, 60);
			repeat (seg) begin
				@(negedge clk);
				n++;
				case (mode)
					0: begin
						rsp_ch.ready <= 1'b1;
					end
					1: begin
						rsp_ch.ready <= ($urandom_range(0, 99) < 70);
					end
					2: begin
						rsp_ch.ready <= (n % 3 == 0);
					end
					default: begin
						rsp_ch.ready <= 1'($urandom_range(0, 1));
					end
				endcase
			end
		end
	end

	initial begin : stimulus
		errors = 0;
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_wdata           <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.func         <= ebam_pkg::FUNC_READ;
		req_ch.access_size  <= ebam_pkg::SIZE_BYTE;
		req_ch.byte_address <= '0;
		req_ch.write_data   <= '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, little-endian: aligned and unaligned hits, both ends of
		// memory, accesses that straddle or wrap past the top, unused size.
		set_byte_order(1'b0);
		drive_item(mk(ebam_pkg::FUNC_WRITE, ebam_pkg::SIZE_WORD, 32'd0, 32'h1122_3344));
		drive_item(mk(ebam_pkg::FUNC_READ,  ebam_pkg::SIZE_WORD, 32'd0, 32'd0));
		drive_item(mk(ebam_pkg::FUNC_READ,  ebam_pkg::SIZE_HALF, 32'd1, 32'd0));
		drive_item(mk(ebam_pkg::FUNC_READ,  ebam_pkg::SIZE_BYTE, 32'd3, 32'd0));
		drive_item(mk(ebam_pkg::FUNC_WRITE, ebam_pkg::SIZE_WORD, 32'd4, 32'hAABB_CCDD));
		drive_item(mk(ebam_pkg::FUNC_READ,  ebam_pkg::SIZE_WORD, 32'd3, 32'd0));
		drive_item(mk(ebam_pkg::FUNC_WRITE, ebam_pkg::SIZE_BYTE, 32'd2, 32'hFFFF_FFFF));
		drive_item(mk(ebam_pkg::FUNC_READ,  ebam_pkg::SIZE_WORD, 32'd0, 32'd0));
		drive_item(mk(ebam_pkg::FUNC_WRITE, ebam_pkg::SIZE_HALF, 32'd9, 32'hFFFF_0000));
		drive_item(mk(ebam_pkg::FUNC_READ,  ebam_pkg::SIZE_HALF, 32'd9, 32'd0));
		drive_item(mk(ebam_pkg::FUNC_WRITE, ebam_pkg::SIZE_WORD, 32'd7, 32'hDEAD_BEEF));
		drive_item(mk(ebam_pkg::FUNC_READ,  ebam_pkg::SIZE_WORD, 32'd7, 32'd0));
		drive_item(mk(ebam_pkg::FUNC_READ,  ebam_pkg::SIZE_HALF, 32'd9, 32'd0));
		drive_item(mk(ebam_pkg::FUNC_WRITE, ebam_pkg::SIZE_WORD, MEM_SZ - 4, 32'hFFFF_FFFF));
		drive_item(mk(ebam_pkg::FUNC_READ,  ebam_pkg::SIZE_WORD, MEM_SZ - 4, 32'd0));
		drive_item(mk(ebam_pkg::FUNC_READ,  ebam_pkg::SIZE_HALF, MEM_SZ - 2, 32'd0));
		drive_item(mk(ebam_pkg::FUNC_READ,  ebam_pkg::SIZE_BYTE, MEM_SZ - 1, 32'd0));
		drive_item(mk(ebam_pkg::FUNC_READ,  ebam_pkg::SIZE_WORD, MEM_SZ - 3, 32'd0));
		drive_item(mk(ebam_pkg::FUNC_WRITE, ebam_pkg::SIZE_HALF, MEM_SZ - 1, 32'h5A5A_5A5A));
		drive_item(mk(ebam_pkg::FUNC_READ,  ebam_pkg::SIZE_BYTE, MEM_SZ, 32'd0));
		drive_item(mk(ebam_pkg::FUNC_WRITE, ebam_pkg::SIZE_WORD, 32'hFFFF_FFFF, 32'h0BAD_F00D));
		drive_item(mk(ebam_pkg::FUNC_READ,  ebam_pkg::SIZE_WORD, 32'hFFFF_FFFC, 32'd0));
		drive_item(mk(ebam_pkg::FUNC_READ,  SIZE_UNUSED, 32'd0, 32'd0));
		drive_item(mk(ebam_pkg::FUNC_WRITE, SIZE_UNUSED, 32'd4, 32'd0));
		// none of the failed writes may have touched the low bytes
		drive_item(mk(ebam_pkg::FUNC_READ,  ebam_pkg::SIZE_WORD, 32'd4, 32'd0));

		// Random phases, flipping byte order between them so data stored in
		// one order is read back in the other.
		in_random = 1'b1;
		for (int p = 0; p < 4; p++) begin
			set_byte_order(p % 2 == 0);
			run_random(PHASE_ITEMS);
		end

		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (errors == 0)
			$display("endian_byte_addressed_memory verification clean");
		else
			$display("endian_byte_addressed_memory verification failed");
		$finish;
	end

	initial begin : watchdog
		#RUN_LIMIT;
		$display("endian_byte_addressed_memory verification failed");
		$finish;
	end

endmodule
